// ----- hdl/rational_arithmetic_unit_defines.svh -----
// Assertion macros for the rational arithmetic unit.
// Used by the top level; no other dependencies.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define RAU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// property checked in the cycle after the antecedent
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/rau_pkg.sv -----
// Shared types and constants for the rational arithmetic unit.
// No dependencies.
package rau_pkg;
  localparam int WordWidth = 32;
  localparam int DenWidth  = WordWidth - 1;
  localparam int WideWidth = 2 * WordWidth;
  localparam int CntWidth  = $clog2(WideWidth + 1);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [WideWidth-1:0] nm;
    logic [WideWidth-1:0] dm;
    logic                 neg;
    logic                 zden;
  } raw_t;
endpackage

// ----- hdl/rational_arithmetic_unit.sv -----
// Rational arithmetic unit: add, subtract, multiply, divide of fractions with
// GCD reduction. The front takes one item at a time through its multiply and sum
// states, then the back end runs Euclid steps and two final divisions, all
// in one shared bit-serial 64-bit divider; a two-entry queue lets the front
// accept the next item while the back works. Zero numerators skip reduction.
`include "rational_arithmetic_unit_defines.svh"
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_a_num,
  input  logic [30:0] in_a_den,
  input  logic [31:0] in_b_num,
  input  logic [30:0] in_b_den,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_res_num,
  output logic [30:0] out_res_den,
  output logic [1:0]  out_status
);
  logic f_valid, f_stall, b_valid, b_stall;
  raw_t f_data, b_data;

  rau_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_a_num, .in_a_den,
    .in_b_num, .in_b_den, .q_valid(f_valid), .q_stall(f_stall), .q_data(f_data)
  );
  rau_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_data),
    .rd_valid(b_valid), .rd_stall(b_stall), .rd_data(b_data)
  );
  rau_back u_back (
    .clk, .rst_n, .q_valid(b_valid), .q_stall(b_stall), .q_data(b_data),
    .out_valid, .out_stall, .out_res_num, .out_res_den, .out_status
  );

  `RAU_ASSERT_IMPL(a_status_range, out_valid, out_status != 2'd3, "bad status")
  `RAU_ASSERT_IMPL(a_err_zero, out_valid && out_status != ST_OK,
    out_res_num == '0 && out_res_den == '0, "error result not zero")
  `RAU_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_res_num), "stalled result changed")
endmodule

// ----- hdl/rau_front.sv -----
// Front end: accepts items, forms raw numerator and denominator magnitudes.
// Depends on rau_pkg. Registers cross products, then sums and magnitudes.
module rau_front import rau_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_opcode,
  input  logic [31:0]          in_a_num,
  input  logic [30:0]          in_a_den,
  input  logic [31:0]          in_b_num,
  input  logic [30:0]          in_b_den,
  output logic                 q_valid,
  input  logic                 q_stall,
  output raw_t                 q_data
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_SUM  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [1:0] op_r;
  logic       same_r;
  logic signed [WordWidth-1:0] an_r, bn_r;
  logic [DenWidth-1:0] ad_r, bd_r;
  logic signed [WideWidth-1:0] p0_r, p1_r, d_r;
  raw_t data_r;

  logic signed [WideWidth-1:0] n_w, d_w;
  logic signed [WideWidth-1:0] ade, bde;

  assign in_stall = (state_r != S_IDLE);
  assign q_valid  = (state_r == S_OUT);
  assign q_data   = data_r;
  assign ade = WideWidth'(ad_r);
  assign bde = WideWidth'(bd_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_OUT;
      S_OUT:  if (!q_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    n_w = p0_r;
    d_w = d_r;
    case (op_r)
      OP_ADD: if (same_r) begin
        n_w = WideWidth'(an_r) + WideWidth'(bn_r);
        d_w = ade;
      end else n_w = p0_r + p1_r;
      OP_SUB: if (same_r) begin
        n_w = WideWidth'(an_r) - WideWidth'(bn_r);
        d_w = ade;
      end else n_w = p0_r - p1_r;
      default: n_w = p0_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
    if (state_r == S_IDLE && in_valid) begin
      op_r   <= in_opcode;
      an_r   <= in_a_num;
      bn_r   <= in_b_num;
      ad_r   <= in_a_den;
      bd_r   <= in_b_den;
      same_r <= (in_a_den == in_b_den);
    end
    if (state_r == S_MUL) begin
      case (op_r)
        OP_MUL: begin
          p0_r <= WideWidth'(an_r) * WideWidth'(bn_r);
          d_r  <= ade * bde;
        end
        OP_DIV: begin
          p0_r <= WideWidth'(an_r) * bde;
          d_r  <= ade * WideWidth'(bn_r);
        end
        default: begin
          p0_r <= WideWidth'(an_r) * bde;
          d_r  <= ade * bde;
        end
      endcase
      p1_r <= WideWidth'(bn_r) * ade;
    end
    if (state_r == S_SUM) begin
      data_r.nm   <= n_w[WideWidth-1] ? WideWidth'(-n_w) : n_w;
      data_r.dm   <= d_w[WideWidth-1] ? WideWidth'(-d_w) : d_w;
      data_r.neg  <= n_w[WideWidth-1] ^ d_w[WideWidth-1];
      data_r.zden <= (d_w == '0);
    end
  end
endmodule

// ----- hdl/rau_queue.sv -----
// Two-entry queue between front and back ends.
// Depends on rau_pkg.
module rau_queue import rau_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_stall,
  input  raw_t wr_data,
  output logic rd_valid,
  input  logic rd_stall,
  output raw_t rd_data
);
  raw_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && !wr_stall;
  assign rd = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end
endmodule

// ----- hdl/rau_back.sv -----
// Back end: Euclidean GCD by restoring remainder division, then reduction.
// Depends on rau_pkg. One quotient bit per cycle in a shared divider.
module rau_back import rau_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_stall,
  input  raw_t                 q_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          out_res_num,
  output logic [30:0]          out_res_den,
  output logic [1:0]           out_status
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD  = 3'd1;
  localparam logic [2:0] S_DVN  = 3'd2;
  localparam logic [2:0] S_DVD  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] ret_r;
  logic [WideWidth-1:0] nm_r, dm_r, x_r, y_r;
  logic neg_r;
  logic [WideWidth-1:0] dq_r, dr_r, dd_r;
  logic [CntWidth-1:0] cnt_r;
  logic [WideWidth:0] trial;
  logic [31:0] num_r;
  logic [30:0] den_r;
  logic [1:0] st_r;
  logic [WideWidth-1:0] lim;

  assign q_stall   = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_res_num = num_r;
  assign out_res_den = den_r;
  assign out_status  = st_r;
  assign trial = {dr_r, dq_r[WideWidth-1]} - {1'b0, dd_r};
  assign lim = WideWidth'(1) << (WordWidth - 1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (q_valid) state_nxt = q_data.zden ? S_OUT :
                ((q_data.nm == '0) ? S_FIN : S_GCD);
      S_GCD:  state_nxt = (y_r == '0) ? S_DVN : S_DIV;
      S_DIV:  if (cnt_r == CntWidth'(1)) state_nxt = ret_r;
      S_DVN:  state_nxt = S_DIV;
      S_DVD:  state_nxt = S_DIV;
      S_FIN:  state_nxt = S_OUT;
      S_OUT:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
    unique case (state_r)
      S_IDLE: if (q_valid) begin
        nm_r <= q_data.nm; dm_r <= q_data.dm;
        x_r  <= q_data.nm; y_r  <= q_data.dm;
        neg_r <= q_data.neg;
        num_r <= '0; den_r <= '0; st_r <= ST_ZDEN;
      end
      S_GCD: begin
        if (y_r != '0) begin
          dq_r <= x_r; dr_r <= '0; dd_r <= y_r;
          cnt_r <= CntWidth'(WideWidth); ret_r <= S_GCD;
        end
      end
      S_DIV: begin
        if (!trial[WideWidth]) begin
          dr_r <= trial[WideWidth-1:0];
          dq_r <= {dq_r[WideWidth-2:0], 1'b1};
        end else begin
          dr_r <= {dr_r[WideWidth-2:0], dq_r[WideWidth-1]};
          dq_r <= {dq_r[WideWidth-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CntWidth'(1);
        if (cnt_r == CntWidth'(1)) begin
          if (ret_r == S_GCD) begin
            x_r <= y_r;
            y_r <= trial[WideWidth] ? {dr_r[WideWidth-2:0], dq_r[WideWidth-1]}
                                    : trial[WideWidth-1:0];
          end else if (ret_r == S_DVD) begin
            nm_r <= {dq_r[WideWidth-2:0], ~trial[WideWidth]};
          end else begin
            dm_r <= {dq_r[WideWidth-2:0], ~trial[WideWidth]};
          end
        end
      end
      S_DVN: begin
        dq_r <= nm_r; dr_r <= '0; dd_r <= x_r;
        cnt_r <= CntWidth'(WideWidth); ret_r <= S_DVD;
      end
      S_DVD: begin
        dq_r <= dm_r; dr_r <= '0; dd_r <= x_r;
        cnt_r <= CntWidth'(WideWidth); ret_r <= S_FIN;
      end
      S_FIN: begin
        if (dm_r > lim - 1 || ((neg_r && nm_r != '0) ? nm_r > lim : nm_r > lim - 1)) begin
          num_r <= '0; den_r <= '0; st_r <= ST_OVF;
        end else begin
          num_r <= neg_r ? 32'(-nm_r) : nm_r[31:0];
          den_r <= dm_r[30:0];
          st_r  <= ST_OK;
        end
      end
      default: ;
    endcase
  end
endmodule
